[design/drml_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drml_pkg
// Shared types and constants of the dirty rectangle merge list.
// ----------------------------------------------------------------------------
package drml_pkg;

    // Default number of slots in the rectangle store.
    localparam int CAPACITY_DEF = 32;

    // Reset value of the max_rects register.
    localparam logic [5:0] MAX_RECTS_RST = 6'd32;

    // APB address width; register i sits at byte address 4*i.
    localparam int APB_AW = 3;

    // One stored rectangle: four signed edges, 64 bits in all.
    typedef struct packed {
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic signed [15:0] r;
        logic signed [15:0] b;
    } t_rect;

    // Command codes carried in the mode field.
    typedef enum logic [1:0] {
        MODE_INVAL = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_LIST  = 2'd2
    } t_mode;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_MERGED   = 3'd0,
        ST_APPENDED = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_CLEARED  = 3'd3,
        ST_LISTED   = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    // Control sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PLACE,
        S_RESULT,
        S_LIST
    } t_state;

endpackage

[design/drml_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drml_cmd_if / drml_res_if
// Valid/ready channels for commands into and results out of the merge list.
// ----------------------------------------------------------------------------

// Command channel: one transaction per invalidate, clear or list command.
interface drml_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_right;
    logic signed [15:0] rect_bottom;

    modport source (
        output valid, mode, rect_left, rect_top, rect_right, rect_bottom,
        input  ready
    );
    modport sink (
        input  valid, mode, rect_left, rect_top, rect_right, rect_bottom,
        output ready
    );
endinterface

// Result channel: one or more transactions per invalidate, clear or list command; none for the unused mode code.
interface drml_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [4:0]         entry_index;
    logic signed [15:0] out_left;
    logic signed [15:0] out_top;
    logic signed [15:0] out_right;
    logic signed [15:0] out_bottom;
    logic [5:0]         used_count;
    logic               last;

    modport source (
        output valid, status, entry_index, out_left, out_top, out_right,
               out_bottom, used_count, last,
        input  ready
    );
    modport sink (
        input  valid, status, entry_index, out_left, out_top, out_right,
               out_bottom, used_count, last,
        output ready
    );
endinterface

[design/drml_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drml_store
// Rectangle store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module drml_store
    import drml_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_rect         i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_rect         o_rdata
);

    t_rect r_mem [DEPTH];
    t_rect r_rdata;

    // Write port; entries carry no reset and are valid only once written.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/dirty_rect_merge_list_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_rect_merge_list_top
// Keeps a list of dirty screen rectangles and merges new ones into it.
// ----------------------------------------------------------------------------
// An invalidate command scans the stored rectangles in slot order through the
// single read port of the rectangle store, one entry per cycle. The first
// entry that touches or overlaps the new rectangle is widened to the bounding
// box of both and written back; otherwise the rectangle is appended while the
// list is below its limit, or dropped. A match ends the scan early. A list
// command emits one entry per cycle while the result channel takes them.
// Commands are handled one at a time; a finished result sits in an output
// register, so the next command is accepted while it waits. Writing max_rects
// over APB empties the list.
// ----------------------------------------------------------------------------
module dirty_rect_merge_list_top
    import drml_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    drml_cmd_if.sink          i_cmd,
    drml_res_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int         AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [6:0] CAP_W = 7'(CAPACITY);

    t_state      r_state, n_state;
    t_mode       w_mode;
    t_rect       r_rect;
    logic [AW-1:0] r_idx;
    logic [5:0]  r_used;
    logic [5:0]  r_max;

    // Pending single result.
    t_status     r_res_status;
    logic [AW-1:0] r_res_idx;
    t_rect       r_res_rect;

    // Output register.
    logic        r_out_valid;
    t_status     r_out_status;
    logic [4:0]  r_out_idx;
    t_rect       r_out_rect;
    logic [5:0]  r_out_used;
    logic        r_out_last;

    logic        w_in_accept;
    logic        w_out_free;
    logic        w_cfg_wr;
    logic [6:0]  w_limit;
    logic        w_can_append;
    logic        w_scan_last;
    logic        w_touch;
    t_rect       w_merged;
    t_rect       w_rd_data;
    t_rect       w_in_rect;

    // Memory and sequencer strobes.
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_rect         w_wdata;
    logic          w_in_ready;
    logic          w_load_res;
    logic          w_load_list;

    // Touch on one axis: the spans overlap or share an edge.
    function automatic logic axis_touch(
        input logic signed [15:0] nlo,
        input logic signed [15:0] nhi,
        input logic signed [15:0] elo,
        input logic signed [15:0] ehi
    );
        logic res;
        if (nlo < elo) begin
            res = (nhi >= elo);
        end else begin
            res = (ehi >= nlo);
        end
        return res;
    endfunction

    assign w_mode       = t_mode'(i_cmd.mode);
    assign w_in_accept  = i_cmd.valid && w_in_ready;
    assign w_out_free   = !r_out_valid || o_res.ready;
    assign w_cfg_wr     = psel && penable && pwrite && !paddr[2];
    assign w_limit      = ({1'b0, r_max} < CAP_W) ? {1'b0, r_max} : CAP_W;
    assign w_can_append = ({1'b0, r_used} < w_limit);
    assign w_scan_last  = ((7'(r_idx) + 7'd1) == {1'b0, r_used});
    assign w_in_rect    = '{l: i_cmd.rect_left, t: i_cmd.rect_top,
                            r: i_cmd.rect_right, b: i_cmd.rect_bottom};

    // Touch test and bounding box against the entry just read.
    always_comb begin
        w_touch    = axis_touch(r_rect.l, r_rect.r, w_rd_data.l, w_rd_data.r) &&
                     axis_touch(r_rect.t, r_rect.b, w_rd_data.t, w_rd_data.b);
        w_merged   = w_rd_data;
        if (r_rect.l < w_rd_data.l) w_merged.l = r_rect.l;
        if (r_rect.r > w_rd_data.r) w_merged.r = r_rect.r;
        if (r_rect.t < w_rd_data.t) w_merged.t = r_rect.t;
        if (r_rect.b > w_rd_data.b) w_merged.b = r_rect.b;
    end

    // Rectangle store.
    drml_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_data)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    case (w_mode)
                        MODE_INVAL: n_state = (r_used != 6'd0) ? S_SCAN : S_PLACE;
                        MODE_CLEAR: n_state = S_RESULT;
                        MODE_LIST:  n_state = (r_used != 6'd0) ? S_LIST : S_RESULT;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_touch) begin
                    n_state = S_RESULT;
                end else if (w_scan_last) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: n_state = S_RESULT;
            S_RESULT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            S_LIST: begin
                if (w_out_free && w_scan_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output logic of the sequencer: memory strobes and result loads.
    always_comb begin
        w_in_ready  = 1'b0;
        w_re        = 1'b0;
        w_raddr     = r_idx + AW'(1);
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = w_merged;
        w_load_res  = 1'b0;
        w_load_list = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
                w_raddr    = '0;
                w_re       = w_in_accept && (r_used != 6'd0) &&
                             ((w_mode == MODE_INVAL) || (w_mode == MODE_LIST));
            end
            S_SCAN: begin
                w_we = w_touch;
                w_re = !w_touch && !w_scan_last;
            end
            S_PLACE: begin
                w_we    = w_can_append;
                w_waddr = r_used[AW-1:0];
                w_wdata = r_rect;
            end
            S_RESULT: begin
                w_load_res = w_out_free;
            end
            S_LIST: begin
                w_load_list = w_out_free;
                w_re        = w_out_free && !w_scan_last;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    // Sequencer state and list control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= 6'd0;
            r_max   <= MAX_RECTS_RST;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_max  <= pwdata[5:0];
                r_used <= 6'd0;
            end else if (r_state == S_IDLE && w_in_accept && w_mode == MODE_CLEAR) begin
                r_used <= 6'd0;
            end else if (r_state == S_PLACE && w_can_append) begin
                r_used <= r_used + 6'd1;
            end
        end
    end

    // Command capture, scan index and pending result.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_accept) begin
            r_rect       <= w_in_rect;
            r_idx        <= '0;
            r_res_idx    <= '0;
            r_res_rect   <= '0;
            r_res_status <= (w_mode == MODE_CLEAR) ? ST_CLEARED : ST_EMPTY;
        end
        if (w_re && r_state != S_IDLE) begin
            r_idx <= r_idx + AW'(1);
        end
        if (r_state == S_SCAN && w_touch) begin
            r_res_status <= ST_MERGED;
            r_res_idx    <= r_idx;
            r_res_rect   <= w_merged;
        end
        if (r_state == S_PLACE) begin
            r_res_rect <= r_rect;
            if (w_can_append) begin
                r_res_status <= ST_APPENDED;
                r_res_idx    <= r_used[AW-1:0];
            end else begin
                r_res_status <= ST_DROPPED;
                r_res_idx    <= '0;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_res || w_load_list) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_load_res) begin
            r_out_status <= r_res_status;
            r_out_idx    <= 5'(r_res_idx);
            r_out_rect   <= r_res_rect;
            r_out_used   <= r_used;
            r_out_last   <= 1'b1;
        end else if (w_load_list) begin
            r_out_status <= ST_LISTED;
            r_out_idx    <= 5'(r_idx);
            r_out_rect   <= w_rd_data;
            r_out_used   <= r_used;
            r_out_last   <= w_scan_last;
        end
    end

    assign i_cmd.ready       = w_in_ready;
    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.entry_index = r_out_idx;
    assign o_res.out_left    = r_out_rect.l;
    assign o_res.out_top     = r_out_rect.t;
    assign o_res.out_right   = r_out_rect.r;
    assign o_res.out_bottom  = r_out_rect.b;
    assign o_res.used_count  = r_out_used;
    assign o_res.last        = r_out_last;

    // APB read side; only max_rects is mapped.
    assign prdata = paddr[2] ? 32'd0 : {26'd0, r_max};
    assign pready = 1'b1;

endmodule

[design/drml_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drml_chk
// Port-level checks on the result channel of the merge list.
// ----------------------------------------------------------------------------
module drml_chk
    import drml_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [2:0]  i_status,
    input logic [4:0]  i_entry_index,
    input logic [15:0] i_left,
    input logic [5:0]  i_used_count,
    input logic        i_last
);

    // A stalled result transaction holds its status, index, left edge, count and last flag.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) &&
        $stable(i_entry_index) && $stable(i_left) && $stable(i_used_count) &&
        $stable(i_last))
        else $error("result payload changed while stalled");

    // Clear and empty-list results leave no entries and end the command.
    a_zero_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_CLEARED || i_status == ST_EMPTY) |->
        i_used_count == 6'd0 && i_last)
        else $error("clear or empty result with nonzero count");

    // An appended rectangle lands in the last used slot.
    a_append_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ST_APPENDED |->
        i_used_count != 6'd0 && i_entry_index == 5'(i_used_count - 6'd1) && i_last)
        else $error("append slot does not match entry count");

    // The final listed entry is the last used slot.
    a_list_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ST_LISTED && i_last |->
        i_entry_index == 5'(i_used_count - 6'd1))
        else $error("list ended before the last used slot");

endmodule

bind dirty_rect_merge_list_top drml_chk u_drml_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_res.valid),
    .i_ready       (o_res.ready),
    .i_status      (o_res.status),
    .i_entry_index (o_res.entry_index),
    .i_left        (o_res.out_left),
    .i_used_count  (o_res.used_count),
    .i_last        (o_res.last)
);

[tb/sv/dirty_rect_merge_list_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_rect_merge_list_top_tb
// Self-checking testbench for the dirty rectangle merge list.
// ----------------------------------------------------------------------------
// Commands go in over the command channel and every accepted command is run
// through a local copy of the merge list, which queues the results it should
// produce. A checker pops that queue on every result transaction and compares
// field by field. The tests cover the directed corner cases, the entry limit
// at its extremes, a completely full store, a long output stall that backs
// up the command channel, and random traffic under several idle patterns.
// ----------------------------------------------------------------------------
module dirty_rect_merge_list_top_tb;
    import drml_pkg::*;

    // Register map and the command code that the block ignores.
    localparam logic [APB_AW-1:0] REG_MAX_RECTS = '0;
    localparam logic [1:0]        MODE_IGNORED  = 2'd3;
    localparam int                SETTLE_CYCLES = 40;

    // One command as driven, and one result as the block should return it.
    typedef struct packed {
        logic [1:0] mode;
        t_rect      box;
    } t_cmd;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] idx;
        t_rect      box;
        logic [5:0] used;
        logic       last;
    } t_rect_res;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    drml_cmd_if cmd_if ();
    drml_res_if res_if ();

    // Local copy of the list state and the limit register.
    t_rect       list_store [CAPACITY_DEF];
    int unsigned list_used;
    int unsigned cfg_max_rects;

    // Results still owed by the block, oldest first.
    t_rect_res   due_results [$];

    int          err_count     = 0;
    int          tx_idle_pct   = 0;
    int          rx_stall_pct  = 0;
    int          rx_hold_cycles = 0;

    dirty_rect_merge_list_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    // Result ready: a long hold-off takes priority over random stalls.
    always @(negedge clk) begin
        if (rx_hold_cycles > 0) begin
            res_if.ready   <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Spans touch when they overlap or share an edge.
    function automatic bit span_touch(logic signed [15:0] nlo, logic signed [15:0] nhi,
                                      logic signed [15:0] elo, logic signed [15:0] ehi);
        if (nlo < elo)
            return nhi >= elo;
        return ehi >= nlo;
    endfunction

    // Apply one accepted command to the local list and queue its results.
    function automatic void predict_rect_list(t_cmd c);
        t_rect_res   r;
        bit          hit;
        int unsigned lim;
        r   = '0;
        hit = 1'b0;
        case (c.mode)
            MODE_INVAL: begin
                for (int i = 0; i < list_used; i++) begin
                    if (!hit && span_touch(c.box.l, c.box.r, list_store[i].l, list_store[i].r)
                             && span_touch(c.box.t, c.box.b, list_store[i].t, list_store[i].b))
                    begin
                        if (c.box.l < list_store[i].l) list_store[i].l = c.box.l;
                        if (c.box.r > list_store[i].r) list_store[i].r = c.box.r;
                        if (c.box.t < list_store[i].t) list_store[i].t = c.box.t;
                        if (c.box.b > list_store[i].b) list_store[i].b = c.box.b;
                        hit      = 1'b1;
                        r.status = ST_MERGED;
                        r.idx    = 5'(i);
                        r.box    = list_store[i];
                    end
                end
                if (!hit) begin
                    lim = (cfg_max_rects < CAPACITY_DEF) ? cfg_max_rects : CAPACITY_DEF;
                    r.box = c.box;
                    if (list_used < lim) begin
                        list_store[list_used] = c.box;
                        r.status  = ST_APPENDED;
                        r.idx     = 5'(list_used);
                        list_used = list_used + 1;
                    end else begin
                        r.status = ST_DROPPED;
                    end
                end
                r.used = 6'(list_used);
                r.last = 1'b1;
                due_results.push_back(r);
            end
            MODE_CLEAR: begin
                list_used = 0;
                r.status  = ST_CLEARED;
                r.last    = 1'b1;
                due_results.push_back(r);
            end
            MODE_LIST: begin
                if (list_used == 0) begin
                    r.status = ST_EMPTY;
                    r.last   = 1'b1;
                    due_results.push_back(r);
                end
                for (int i = 0; i < list_used; i++) begin
                    r.status = ST_LISTED;
                    r.idx    = 5'(i);
                    r.box    = list_store[i];
                    r.used   = 6'(list_used);
                    r.last   = (i + 1 == list_used);
                    due_results.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    // Compare every result transaction with the oldest expectation.
    always @(posedge clk) begin : res_check
        t_rect_res want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual status %0d index %0d",
                         $time, res_if.status, res_if.entry_index);
                err_count++;
            end else begin
                want = due_results.pop_front();
                check_field("status", int'(want.status), int'(res_if.status));
                check_field("entry_index", int'(want.idx), int'(res_if.entry_index));
                check_field("out_left", int'($signed(want.box.l)),
                            int'($signed(res_if.out_left)));
                check_field("out_top", int'($signed(want.box.t)),
                            int'($signed(res_if.out_top)));
                check_field("out_right", int'($signed(want.box.r)),
                            int'($signed(res_if.out_right)));
                check_field("out_bottom", int'($signed(want.box.b)),
                            int'($signed(res_if.out_bottom)));
                check_field("used_count", int'(want.used), int'(res_if.used_count));
                check_field("last", int'(want.last), int'(res_if.last));
            end
        end
    end

    function automatic t_cmd make_cmd(logic [1:0] mode, int l, int t, int r, int b);
        t_cmd c;
        c.mode  = mode;
        c.box.l = 16'(l);
        c.box.t = 16'(t);
        c.box.r = 16'(r);
        c.box.b = 16'(b);
        return c;
    endfunction

    // Offer one command after a random gap and wait for its transaction.
    task automatic send_cmd(input t_cmd c);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.mode        <= c.mode;
        cmd_if.rect_left   <= c.box.l;
        cmd_if.rect_top    <= c.box.t;
        cmd_if.rect_right  <= c.box.r;
        cmd_if.rect_bottom <= c.box.b;
        do @(posedge clk); while (!cmd_if.ready);
        predict_rect_list(c);
    endtask

    // Stop offering commands and wait until the block has gone quiet.
    task automatic drain();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [APB_AW-1:0] addr, input logic [31:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: register read mismatch: expected %0d, actual %0d",
                     $time, want, prdata);
            err_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Change the entry limit while idle; the write also empties the list.
    task automatic set_max_rects(input logic [5:0] value);
        drain();
        apb_write(REG_MAX_RECTS, {26'd0, value});
        cfg_max_rects = 32'(value);
        list_used     = 0;
        apb_read_check(REG_MAX_RECTS, {26'd0, value});
    endtask

    // Rectangles mostly in a small cluster so that merges are common.
    function automatic t_rect rand_rect();
        t_rect b;
        int    x;
        int    y;
        int    w;
        int    h;
        int    kind;
        x    = int'($urandom_range(400)) - 200;
        y    = int'($urandom_range(400)) - 200;
        w    = int'($urandom_range(40));
        h    = int'($urandom_range(40));
        kind = int'($urandom_range(99));
        if (kind < 65) begin
            b = '{l: 16'(x), t: 16'(y), r: 16'(x + w), b: 16'(y + h)};
        end else if (kind < 75) begin
            // Inverted edges are used exactly as given.
            b = '{l: 16'(x + w), t: 16'(y + h), r: 16'(x), b: 16'(y)};
        end else if (kind < 87) begin
            b = '{l: 16'($urandom), t: 16'($urandom), r: 16'($urandom), b: 16'($urandom)};
        end else if (kind < 94) begin
            b = '{l: 16'(-32768), t: 16'(-32768), r: 16'(-32768 + w), b: 16'(-32768 + h)};
        end else begin
            b = '{l: 16'(32767 - w), t: 16'(32767 - h), r: 16'(32767), b: 16'(32767)};
        end
        return b;
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int   pick;
        pick  = int'($urandom_range(99));
        c.box = rand_rect();
        if (pick < 76)
            c.mode = MODE_INVAL;
        else if (pick < 86)
            c.mode = MODE_LIST;
        else if (pick < 93)
            c.mode = MODE_CLEAR;
        else
            c.mode = MODE_IGNORED;
        return c;
    endfunction

    // Reset value of the register, shared edges, no cascade, extreme edges,
    // inverted edges, every command, and the ignored command code.
    task automatic test_directed_cases();
        apb_read_check(REG_MAX_RECTS, {26'd0, MAX_RECTS_RST});
        send_cmd(make_cmd(MODE_LIST, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_INVAL, 0, 0, 10, 10));
        send_cmd(make_cmd(MODE_INVAL, 11, 0, 20, 10));
        send_cmd(make_cmd(MODE_INVAL, 10, 10, 10, 20));
        send_cmd(make_cmd(MODE_INVAL, 5, 5, 15, 5));
        send_cmd(make_cmd(MODE_INVAL, -32768, -32768, -32768, -32768));
        send_cmd(make_cmd(MODE_INVAL, 32767, 32767, 32767, 32767));
        send_cmd(make_cmd(MODE_INVAL, 32767, -32768, -32768, 32767));
        send_cmd(make_cmd(MODE_INVAL, 16'h5555, 16'haaaa, 16'h2aaa, 16'h5554));
        send_cmd(make_cmd(MODE_INVAL, 300, 300, 200, 200));
        send_cmd(make_cmd(MODE_LIST, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_IGNORED, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        send_cmd(make_cmd(MODE_CLEAR, 1, 2, 3, 4));
        send_cmd(make_cmd(MODE_LIST, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_INVAL, 0, 0, 0, 0));
        drain();
    endtask

    // A limit of zero drops everything, a limit of one merges or drops.
    task automatic test_limit_settings();
        set_max_rects(6'd0);
        send_cmd(make_cmd(MODE_INVAL, 1, 1, 5, 5));
        send_cmd(make_cmd(MODE_LIST, 0, 0, 0, 0));
        set_max_rects(6'd1);
        send_cmd(make_cmd(MODE_INVAL, 0, 0, 8, 8));
        send_cmd(make_cmd(MODE_INVAL, 100, 100, 110, 110));
        send_cmd(make_cmd(MODE_INVAL, 8, -4, 12, 0));
        send_cmd(make_cmd(MODE_LIST, 0, 0, 0, 0));
        drain();
    endtask

    // A limit above the capacity saturates: the store fills, then drops.
    task automatic test_capacity_fill();
        int l;
        int t;
        set_max_rects(6'd63);
        for (int i = 0; i <= CAPACITY_DEF; i++) begin
            l = -32000 + i * 1000 + int'($urandom_range(100));
            t = int'($urandom_range(20000)) - 10000;
            send_cmd(make_cmd(MODE_INVAL, l, t, l + int'($urandom_range(500)),
                              t + int'($urandom_range(500))));
        end
        send_cmd(make_cmd(MODE_LIST, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_INVAL, -32768, -32768, 32767, 32767));
        send_cmd(make_cmd(MODE_LIST, 0, 0, 0, 0));
        drain();
    endtask

    // Hold the result channel off while commands keep coming.
    task automatic test_output_backpressure();
        set_max_rects(6'd32);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        @(posedge clk);
        rx_hold_cycles = 400;
        for (int i = 0; i < 12; i++)
            send_cmd(make_cmd(MODE_INVAL, i * 3, 0, i * 3 + 1, 1));
        send_cmd(make_cmd(MODE_LIST, 0, 0, 0, 0));
        drain();
    endtask

    task automatic run_random_phase(input int tx_pct, input int rx_pct,
                                    input logic [5:0] limit, input int count);
        set_max_rects(limit);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < count; i++)
            send_cmd(rand_cmd());
        drain();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 6'd32, 23);
        run_random_phase(84, 0, 6'd6, 23);
        run_random_phase(0, 84, 6'd2, 23);
        run_random_phase(29, 29, 6'd40, 23);
    endtask

    initial begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cmd_if.valid       = 1'b0;
        cmd_if.mode        = MODE_INVAL;
        cmd_if.rect_left   = '0;
        cmd_if.rect_top    = '0;
        cmd_if.rect_right  = '0;
        cmd_if.rect_bottom = '0;
        res_if.ready       = 1'b0;
        list_used          = 0;
        cfg_max_rects      = 32'(MAX_RECTS_RST);
        for (int i = 0; i < CAPACITY_DEF; i++)
            list_store[i] = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_limit_settings();
        test_capacity_fill();
        test_output_backpressure();
        test_random_traffic();
        drain();

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
